/* hw/rtl/hkrb_pkg.sv */
// Shared types, codes and constants of the keyboard report builder.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package hkrb_pkg;

  // Report layout: two halves of 40 bytes each in one store.
  localparam int unsigned REPORT_BYTES = 40;
  localparam int unsigned MEM_DEPTH    = 2 * REPORT_BYTES;
  localparam int unsigned ADDR_W       = $clog2(MEM_DEPTH);
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned CNT_W        = 3;

  localparam logic [IDX_W-1:0] MOD_BYTE   = IDX_W'(0);
  localparam logic [IDX_W-1:0] SLOT_BASE  = IDX_W'(2);
  localparam logic [IDX_W-1:0] BMP_BASE   = IDX_W'(8);
  localparam logic [IDX_W-1:0] LAST_BYTE  = IDX_W'(REPORT_BYTES - 1);
  localparam logic [CNT_W-1:0] BOOT_SLOTS = CNT_W'(6);
  localparam logic [CNT_W-1:0] ROLL_LAST  = CNT_W'(5);
  localparam logic [7:0]       ROLL_VALUE = 8'h01;
  // Usage codes 0xE0..0xE7 share this upper five-bit prefix.
  localparam logic [4:0]       MOD_PREFIX = 5'b11100;

  // Input actions.
  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_KEY   = 3'd1;
  localparam logic [2:0] ACT_CONS  = 3'd2;
  localparam logic [2:0] ACT_FIN   = 3'd3;
  localparam logic [2:0] ACT_OUT   = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_CONS = 2'd1;
  localparam logic [1:0] KIND_WAKE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_DISABLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_BMP,
    ST_KEY_MOD,
    ST_KEY_SLOT,
    ST_KEY_ROLL,
    ST_OUT_BYTE,
    ST_OUT_CONS,
    ST_WAKE
  } state_t;

  // Request from the sequencer to the report store.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clr_en;
    logic              clr_half;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic half,
                                                 input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = half ? ADDR_W'(REPORT_BYTES) : ADDR_W'(0);
    return base + ADDR_W'(idx);
  endfunction

endpackage

/* hw/rtl/hkrb_mem.sv */
// Report store: 80 x 8 synchronous memory with registered read.
// Per-entry valid bits give the all-zero reset and the half clear.
// Depends on hkrb_pkg.
`timescale 1ns / 1ps

module hkrb_mem (
  input  logic              clk,
  input  logic              rst,
  input  hkrb_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);
  import hkrb_pkg::*;

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (req.clr_en) begin
        for (int i = 0; i < int'(MEM_DEPTH); i++) begin
          if ((i >= int'(REPORT_BYTES)) == req.clr_half) begin
            valid[i] <= 1'b0;
          end
        end
      end
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // An entry that was never written since its last clear reads as zero.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : 8'h00;
    end
  end

endmodule

/* hw/rtl/hkrb_seq.sv */
// Sequencer: decodes items, runs read-modify-write steps on the report store
// and streams reports through the output register. Depends on hkrb_pkg.
`timescale 1ns / 1ps

module hkrb_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,
  input  logic [2:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,
  output logic [1:0]         m_tuser,
  output logic               m_tlast,
  output hkrb_pkg::mem_req_t req,
  input  logic [7:0]         rd_data
);
  import hkrb_pkg::*;

  state_t                   state, state_next;
  logic [7:0]               key, key_next;
  logic [CNT_W-1:0]         slot_cnt, slot_cnt_next;
  logic [CNT_W-1:0]         roll, roll_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic                     front, front_next;
  logic                     pending, pending_next;
  logic [15:0]              consumer, consumer_next;
  logic                     cfg_mode, cfg_dis;
  logic                     out_valid_next, out_last_next;
  logic [1:0]               out_kind_next;
  logic [IDX_W-1:0]         out_idx, out_idx_next;
  logic [15:0]              out_value, out_value_next;
  logic                     out_free;
  logic [15:0]              in_code;
  logic                     in_susp, in_ready;

  assign in_code  = s_tdata[15:0];
  assign in_susp  = s_tdata[16];
  assign in_ready = s_tdata[17];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {2'b00, out_value, out_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode <= 1'b0;
      cfg_dis  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:    cfg_mode <= cfg_data;
        CFG_DISABLE: cfg_dis  <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot_cnt <= '0;
      front    <= 1'b0;
      pending  <= 1'b0;
      consumer <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      slot_cnt <= slot_cnt_next;
      front    <= front_next;
      pending  <= pending_next;
      consumer <= consumer_next;
      m_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key       <= key_next;
    roll      <= roll_next;
    idx       <= idx_next;
    m_tuser   <= out_kind_next;
    m_tlast   <= out_last_next;
    out_idx   <= out_idx_next;
    out_value <= out_value_next;
  end

  always_comb begin
    state_next     = state;
    key_next       = key;
    slot_cnt_next  = slot_cnt;
    roll_next      = roll;
    idx_next       = idx;
    front_next     = front;
    pending_next   = pending;
    consumer_next  = consumer;
    out_valid_next = m_tvalid && !m_tready;
    out_kind_next  = m_tuser;
    out_last_next  = m_tlast;
    out_idx_next   = out_idx;
    out_value_next = out_value;
    req            = '0;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            ACT_START: begin
              req.clr_en    = 1'b1;
              req.clr_half  = !front;
              consumer_next = '0;
            end
            ACT_KEY: begin
              key_next    = in_code[7:0];
              req.rd_en   = 1'b1;
              req.rd_addr = mem_addr(!front, BMP_BASE + IDX_W'(in_code[7:3]));
              state_next  = ST_KEY_BMP;
            end
            ACT_CONS: begin
              consumer_next = in_code;
            end
            ACT_FIN: begin
              front_next    = !front;
              pending_next  = (slot_cnt != '0);
              slot_cnt_next = '0;
            end
            ACT_OUT: begin
              if (!(cfg_mode || cfg_dis)) begin
                if (in_susp && pending) begin
                  state_next = ST_WAKE;
                end else if (in_ready) begin
                  idx_next    = '0;
                  req.rd_en   = 1'b1;
                  req.rd_addr = mem_addr(front, MOD_BYTE);
                  state_next  = ST_OUT_BYTE;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_KEY_BMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = mem_addr(!front, BMP_BASE + IDX_W'(key[7:3]));
        req.wr_data = rd_data | (8'h01 << key[2:0]);
        if (key[7:3] == MOD_PREFIX) begin
          req.rd_en   = 1'b1;
          req.rd_addr = mem_addr(!front, MOD_BYTE);
          state_next  = ST_KEY_MOD;
        end else if (slot_cnt < BOOT_SLOTS) begin
          state_next = ST_KEY_SLOT;
        end else begin
          roll_next  = '0;
          state_next = ST_KEY_ROLL;
        end
      end

      ST_KEY_MOD: begin
        req.wr_en   = 1'b1;
        req.wr_addr = mem_addr(!front, MOD_BYTE);
        req.wr_data = rd_data | (8'h01 << key[2:0]);
        state_next  = ST_IDLE;
      end

      ST_KEY_SLOT: begin
        req.wr_en     = 1'b1;
        req.wr_addr   = mem_addr(!front, SLOT_BASE + IDX_W'(slot_cnt));
        req.wr_data   = key;
        slot_cnt_next = slot_cnt + CNT_W'(1);
        state_next    = ST_IDLE;
      end

      // Rollover marks all six boot key bytes, one write per cycle.
      ST_KEY_ROLL: begin
        req.wr_en   = 1'b1;
        req.wr_addr = mem_addr(!front, SLOT_BASE + IDX_W'(roll));
        req.wr_data = ROLL_VALUE;
        if (roll == ROLL_LAST) begin
          state_next = ST_IDLE;
        end else begin
          roll_next = roll + CNT_W'(1);
        end
      end

      // rd_data holds byte idx until the output register can take it;
      // the read of the next byte is issued in the same cycle as the load.
      ST_OUT_BYTE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_BYTE;
          out_last_next  = 1'b0;
          out_idx_next   = idx;
          out_value_next = {8'h00, rd_data};
          if (idx == LAST_BYTE) begin
            state_next = ST_OUT_CONS;
          end else begin
            idx_next    = idx + IDX_W'(1);
            req.rd_en   = 1'b1;
            req.rd_addr = mem_addr(front, idx + IDX_W'(1));
          end
        end
      end

      ST_OUT_CONS: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_CONS;
          out_last_next  = 1'b1;
          out_idx_next   = '0;
          out_value_next = consumer;
          state_next     = ST_IDLE;
        end
      end

      ST_WAKE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_WAKE;
          out_last_next  = 1'b1;
          out_idx_next   = '0;
          out_value_next = '0;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/hid_keyboard_report_builder.sv */
// Keyboard report builder. Output tick: one beat per cycle without backpressure;
// 41 beats for a report, a single beat for a wakeup. Key press: a read-modify-write
// of the bitmap byte, then of the modifier byte, or a write of a free key slot, or on
// rollover (one store write per byte). Start, consumer, finalize and suppressed output
// ticks complete in the idle state. Reset is synchronous; store valid bits clear at once, no clearing pass.
`timescale 1ns / 1ps

module hid_keyboard_report_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // code[15:0], host_suspended[16], host_ready[17]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // byte_index[5:0], value[21:6]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);
  import hkrb_pkg::*;

  mem_req_t   req;
  logic [7:0] rd_data;

  hkrb_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  hkrb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .req       (req),
    .rd_data   (rd_data)
  );

`ifndef SYNTHESIS
  // Consumer and wakeup beats always close an output tick.
  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_CONS || m_tuser == KIND_WAKE) |-> m_tlast)
    else $error("consumer or wakeup beat without last");

  // Report bytes are never last and stay inside the report.
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_BYTE |-> !m_tlast && m_tdata[5:0] <= LAST_BYTE)
    else $error("report byte beat out of range or marked last");

  // An accepted key press always leaves the idle state to update the store, which drops s_tready.
  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ACT_KEY |=> !s_tready)
    else $error("input accepted during key press update");
`endif

endmodule
